@@ hdl/triangle_face_normal_store_defines.svh @@
// Assertion macros for the face normal store
`ifndef TRIANGLE_FACE_NORMAL_STORE_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_STORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define TFN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition that must hold on the next clock edge
`define TFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ hdl/tfn_pkg.sv @@
// Shared types and constants for the face normal store
package tfn_pkg;
  localparam int MaxVertices = 1024;
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_TRI  = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic        cap;      // capture the input word
    logic        rd_pos;   // issue position read (sel picks corner)
    logic [1:0]  sel;      // 0 a, 1 b, 2 c
    logic        lat_pos;  // latch position read data into slot sel
    logic        rd_nrm;   // issue normal read at vertex index
    logic        lat_nrm;  // latch normal data as the vector
    logic        edge_go;  // form edge vectors
    logic        cross_go; // one cross term per cycle, step in sel
    logic        sq_go;    // squares, step in sel
    logic        norm_init;
    logic        norm_step;
    logic        comp_next;
    logic        wr_load;
    logic        wr_nrm;
    logic        emit;
  } ctrl_t;

  typedef struct packed {
    logic        bs_done;
    logic        zero;
    logic        in_range;
    logic [1:0]  op;
  } stat_t;
endpackage

@@ hdl/tfn_ctrl.sv @@
// Controller state machine for the face normal store
module tfn_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  tfn_pkg::stat_t  st,
  output tfn_pkg::ctrl_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_PRD = 4'd2, S_PLT = 4'd3,
                         S_EDGE = 4'd4, S_CROSS = 4'd5, S_NRD = 4'd6, S_NLT = 4'd7,
                         S_SQ = 4'd8, S_BINIT = 4'd9, S_BSTEP = 4'd10, S_FIN = 4'd11;
  logic [3:0] state, state_next;
  logic [1:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= 2'd0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.sel = cnt;
    state_next = state;
    cnt_next = cnt;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.cap = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cnt_next = 2'd0;
        if (st.op == tfn_pkg::OP_LOAD) begin
          cmd.wr_load = st.in_range;
          state_next = S_IDLE;
        end else if (st.op == tfn_pkg::OP_TRI) begin
          state_next = st.in_range ? S_PRD : S_IDLE;
        end else if (st.op == tfn_pkg::OP_READ) begin
          if (st.in_range) state_next = S_NRD;
          else begin
            cmd.emit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PRD: begin
        cmd.rd_pos = 1'b1;
        state_next = S_PLT;
      end
      S_PLT: begin
        cmd.lat_pos = 1'b1;
        if (cnt == 2'd2) begin
          cnt_next = 2'd0;
          state_next = S_EDGE;
        end else begin
          cnt_next = cnt + 2'd1;
          state_next = S_PRD;
        end
      end
      S_EDGE: begin
        cmd.edge_go = 1'b1;
        state_next = S_CROSS;
      end
      S_CROSS: begin
        cmd.cross_go = 1'b1;
        if (cnt == 2'd2) begin
          cnt_next = 2'd0;
          state_next = S_SQ;
        end else cnt_next = cnt + 2'd1;
      end
      S_NRD: begin
        cmd.rd_nrm = 1'b1;
        state_next = S_NLT;
      end
      S_NLT: begin
        cmd.lat_nrm = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq_go = 1'b1;
        if (cnt == 2'd2) begin
          cnt_next = 2'd0;
          state_next = S_BINIT;
        end else cnt_next = cnt + 2'd1;
      end
      S_BINIT: begin
        if (st.zero) begin
          if (st.op == tfn_pkg::OP_TRI) cmd.wr_nrm = 1'b1;
          else cmd.emit = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.norm_init = 1'b1;
          state_next = S_BSTEP;
        end
      end
      S_BSTEP: begin
        cmd.norm_step = 1'b1;
        if (st.bs_done) state_next = S_FIN;
      end
      S_FIN: begin
        if (cnt == 2'd2) begin
          cnt_next = 2'd0;
          if (st.op == tfn_pkg::OP_TRI) cmd.wr_nrm = 1'b1;
          else cmd.emit = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.comp_next = 1'b1;
          cnt_next = cnt + 2'd1;
          state_next = S_BSTEP;
          cmd.norm_init = 1'b1;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

@@ hdl/tfn_datapath.sv @@
// Datapath for the face normal store: vertex memories, cross product, normaliser
module tfn_datapath #(
  parameter int MAX_VERTICES = tfn_pkg::MaxVertices
) (
  input  logic               clk,
  input  tfn_pkg::ctrl_t     cmd,
  output tfn_pkg::stat_t     st,
  input  logic [1:0]         opcode,
  input  logic [9:0]         vertex_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] init_nx,
  input  logic signed [15:0] init_ny,
  input  logic signed [15:0] init_nz,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  output logic               strobe,
  output logic [9:0]         out_index,
  output logic signed [15:0] unit_x,
  output logic signed [15:0] unit_y,
  output logic signed [15:0] unit_z,
  output logic               degenerate
);
  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;

  logic [47:0] pos_mem [MAX_VERTICES];
  logic [47:0] nrm_mem [MAX_VERTICES];
  logic [47:0] pos_rd, nrm_rd;

  logic [1:0]  op;
  logic [9:0]  vi, ca, cb, cc;
  logic [47:0] ld_pos, ld_nrm;
  logic        in_range;

  logic signed [15:0] pv [3][3];   // corner, axis
  logic signed [16:0] e1 [3], e2 [3];
  logic signed [35:0] vec [3];
  logic [69:0] s_acc;
  logic [1:0]  comp;
  logic [14:0] lo, hi;
  logic signed [15:0] res [3];

  function automatic logic [AW-1:0] addr_of(input logic [9:0] x);
    logic [AW+9:0] w;
    w = {{AW{1'b0}}, x};
    return w[AW-1:0];
  endfunction

  function automatic logic in_rng(input logic [9:0] x);
    return 32'(x) < MAX_VERTICES;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      op <= opcode;
      vi <= vertex_index;
      ca <= corner_a;
      cb <= corner_b;
      cc <= corner_c;
      ld_pos <= {pos_z, pos_y, pos_x};
      ld_nrm <= {init_nz, init_ny, init_nx};
      if (opcode == tfn_pkg::OP_TRI)
        in_range <= in_rng(corner_a) && in_rng(corner_b) && in_rng(corner_c);
      else
        in_range <= in_rng(vertex_index);
    end
  end

  assign st.op = op;
  assign st.in_range = in_range;

  // memories
  logic [9:0] pra;
  always_comb begin
    case (cmd.sel)
      2'd0: pra = ca;
      2'd1: pra = cb;
      default: pra = cc;
    endcase
  end

  logic [47:0] nrm_wd;
  assign nrm_wd = cmd.wr_load ? ld_nrm : {res[2], res[1], res[0]};

  always_ff @(posedge clk) begin
    if (cmd.wr_load) pos_mem[addr_of(vi)] <= ld_pos;
    if (cmd.rd_pos) pos_rd <= pos_mem[addr_of(pra)];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_load) nrm_mem[addr_of(vi)] <= nrm_wd;
    else if (cmd.wr_nrm) nrm_mem[addr_of(cc)] <= nrm_wd;
    if (cmd.rd_nrm) nrm_rd <= nrm_mem[addr_of(vi)];
  end

  // edges and cross product, one component per cycle
  logic signed [33:0] pa, pb;
  always_comb begin
    case (cmd.sel)
      2'd0: begin
        pa = e1[1] * e2[2];
        pb = e1[2] * e2[1];
      end
      2'd1: begin
        pa = e1[2] * e2[0];
        pb = e1[0] * e2[2];
      end
      default: begin
        pa = e1[0] * e2[1];
        pb = e1[1] * e2[0];
      end
    endcase
  end

  // squaring: |v| < 2^35, square < 2^70
  logic [34:0] mag_sq;
  logic [69:0] sq;
  always_comb begin
    case (cmd.sel)
      2'd0: mag_sq = vec[0][35] ? 35'(-vec[0]) : vec[0][34:0];
      2'd1: mag_sq = vec[1][35] ? 35'(-vec[1]) : vec[1][34:0];
      default: mag_sq = vec[2][35] ? 35'(-vec[2]) : vec[2][34:0];
    endcase
    sq = 70'(mag_sq) * 70'(mag_sq);
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_pos) begin
      pv[cmd.sel][0] <= pos_rd[15:0];
      pv[cmd.sel][1] <= pos_rd[31:16];
      pv[cmd.sel][2] <= pos_rd[47:32];
    end
    if (cmd.edge_go) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= 17'(pv[1][i]) - 17'(pv[2][i]);
        e2[i] <= 17'(pv[0][i]) - 17'(pv[2][i]);
      end
    end
    if (cmd.cross_go) vec[cmd.sel] <= 36'(pa) - 36'(pb);
    if (cmd.lat_nrm) begin
      vec[0] <= 36'(signed'(nrm_rd[15:0]));
      vec[1] <= 36'(signed'(nrm_rd[31:16]));
      vec[2] <= 36'(signed'(nrm_rd[47:32]));
    end
    if (cmd.sq_go) s_acc <= ((cmd.sel == 2'd0) ? 70'd0 : s_acc) + sq;
  end

  assign st.zero = (s_acc == 70'd0);

  // binary search per component: largest k with (2k-1)^2 * S <= 2^30 * v^2
  logic [34:0] cm;
  logic [69:0] cm2;
  logic [99:0] rhs;
  logic [14:0] mid;
  logic [29:0] q2;
  logic [99:0] lhs;
  logic [15:0] q;
  always_comb begin
    case (comp)
      2'd0: cm = vec[0][35] ? 35'(-vec[0]) : vec[0][34:0];
      2'd1: cm = vec[1][35] ? 35'(-vec[1]) : vec[1][34:0];
      default: cm = vec[2][35] ? 35'(-vec[2]) : vec[2][34:0];
    endcase
    mid = 15'((16'(lo) + 16'(hi) + 16'd1) >> 1);
    q = {mid, 1'b0} - 16'd1;
    q2 = 30'(q) * 30'(q);
  end

  // wide products split across cycles: (2k-1)^2 and lhs registered before the compare
  logic [1:0] ph;
  logic [69:0] rhs_sq;
  logic [29:0] q2_r;
  always_ff @(posedge clk) begin
    if (cmd.norm_init) begin
      lo <= 15'd0;
      hi <= 15'd16384;
      ph <= 2'd0;
      if (cmd.comp_next) comp <= comp + 2'd1;
      else if (!cmd.comp_next && ph != 2'd3) comp <= comp;
    end else if (cmd.norm_step) begin
      unique case (ph)
        2'd0: begin
          rhs_sq <= 70'(cm) * 70'(cm);
          q2_r <= q2;
          ph <= 2'd1;
        end
        2'd1: begin
          lhs <= 100'(s_acc[34:0]) * 100'(q2_r) + ((100'(s_acc[69:35]) * 100'(q2_r)) << 35);
          ph <= 2'd2;
        end
        2'd2: begin
          if (lhs <= rhs) lo <= mid;
          else hi <= mid - 15'd1;
          ph <= 2'd3;
        end
        default: begin
          q2_r <= q2;
          ph <= 2'd1;
        end
      endcase
    end
    if (cmd.sq_go) comp <= 2'd0;
  end
  assign rhs = {rhs_sq, 30'd0};
  assign st.bs_done = cmd.norm_step && (ph == 2'd3) && (lo == hi);

  // component result captured when search converges
  logic signed [15:0] kval;
  assign kval = vec[comp][35] ? -16'(lo) : 16'(lo);
  always_ff @(posedge clk) begin
    if (cmd.sq_go) begin
      res[0] <= 16'sd0;
      res[1] <= 16'sd0;
      res[2] <= 16'sd0;
    end else if (st.bs_done) res[comp] <= kval;
  end

  // output word, registered on emit and held on the ports; strobe is high for one cycle
  logic emit_d;
  always_ff @(posedge clk) begin
    emit_d <= cmd.emit;
    if (cmd.emit) begin
      out_index <= vi;
      degenerate <= !in_range || st.zero;
      unit_x <= in_range ? res[0] : 16'sd0;
      unit_y <= in_range ? res[1] : 16'sd0;
      unit_z <= in_range ? res[2] : 16'sd0;
    end
  end
  assign strobe = emit_d;
endmodule

@@ hdl/triangle_face_normal_store.sv @@
// Top level of the triangle face normal store
// Load: decode and write only. Read: setup, then per component a binary search of 14 or 15
// steps; the word is strobed in the first cycle that busy is low.
// Triangle: corner reads, edges and cross terms come before the search.
// Zero-length reads, zero triangles and out-of-range reads end early. A new word is taken while busy is low.
// Synchronous reset returns the controller to idle; vertex memories are not cleared.
`include "triangle_face_normal_store_defines.svh"
module triangle_face_normal_store #(
  parameter int MAX_VERTICES = tfn_pkg::MaxVertices
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [9:0]         vertex_index,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [15:0] pos_z,
  input  logic signed [15:0] init_nx,
  input  logic signed [15:0] init_ny,
  input  logic signed [15:0] init_nz,
  input  logic [9:0]         corner_a,
  input  logic [9:0]         corner_b,
  input  logic [9:0]         corner_c,
  output logic               strobe,
  output logic [9:0]         out_index,
  output logic signed [15:0] unit_x,
  output logic signed [15:0] unit_y,
  output logic signed [15:0] unit_z,
  output logic               degenerate
);
  tfn_pkg::ctrl_t cmd;
  tfn_pkg::stat_t st;

  tfn_ctrl u_ctrl (.clk(clk), .rst(rst), .start(start), .busy(busy), .st(st), .cmd(cmd));

  tfn_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .cmd(cmd), .st(st), .opcode(opcode), .vertex_index(vertex_index),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .init_nx(init_nx), .init_ny(init_ny), .init_nz(init_nz),
    .corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
    .strobe(strobe), .out_index(out_index), .unit_x(unit_x), .unit_y(unit_y),
    .unit_z(unit_z), .degenerate(degenerate)
  );

  `TFN_ASSERT_IMP(a_emit_busy, cmd.emit, busy, "result word issued while idle")
  `TFN_ASSERT_NEXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `TFN_ASSERT_IMP(a_no_dual_wr, cmd.wr_load, !cmd.wr_nrm, "load and normal write together")
endmodule
